@@ rtl/bgc_pkg.sv @@
// shared types and constants for the button gesture classifier
`timescale 1ns / 1ps

package bgc_pkg;

   // register and field widths
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 8;
   localparam int unsigned GESTURE_WIDTH   = 2;
   localparam int unsigned REQ_DATA_WIDTH  = 8;
   localparam int unsigned RSP_DATA_WIDTH  = 8;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_POLLS   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_TICKS = 2'd1;

   // register reset values
   localparam logic [CSR_DATA_WIDTH-1:0] HOLD_POLLS_RESET   = 8'd60;
   localparam logic [CSR_DATA_WIDTH-1:0] WINDOW_TICKS_RESET = 8'd6;

   // gesture codes
   localparam logic [GESTURE_WIDTH-1:0] GESTURE_LONG   = 2'd0;
   localparam logic [GESTURE_WIDTH-1:0] GESTURE_DOUBLE = 2'd1;
   localparam logic [GESTURE_WIDTH-1:0] GESTURE_SINGLE = 2'd2;

   // one classifier result on its way to the output register
   typedef struct packed {
      logic                     valid;
      logic [GESTURE_WIDTH-1:0] gesture;
   } bgc_result_type;

endpackage

@@ rtl/bgc_core.sv @@
// phase state machine, tick counter and edge latch of the classifier
`timescale 1ns / 1ps

module bgc_core #(
   parameter int unsigned COUNT_WIDTH = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   tick_accept,
   input  logic                                   pin_level,
   input  logic                                   press_edge,
   input  logic [bgc_pkg::CSR_DATA_WIDTH-1:0]     hold_polls,
   input  logic [bgc_pkg::CSR_DATA_WIDTH-1:0]     window_ticks,
   output bgc_pkg::bgc_result_type                result,
   output logic                                   phase_idle
);
   import bgc_pkg::*;

   localparam int unsigned LimWidth = (COUNT_WIDTH > CSR_DATA_WIDTH) ?
                                      COUNT_WIDTH : CSR_DATA_WIDTH;
   localparam logic [LimWidth-1:0] CountMax = LimWidth'((1 << COUNT_WIDTH) - 1);

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_HOLD   = 2'd1,
      PHASE_WINDOW = 2'd2
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   edge_ff, edge_in;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic [COUNT_WIDTH-1:0] hold_lim;
   logic [COUNT_WIDTH-1:0] window_lim;
   logic [LimWidth-1:0]    hold_ext;
   logic [LimWidth-1:0]    window_ext;
   logic                   edge_seen;

   // limits: zero acts as one, clamp to the counter range
   always_comb begin
      hold_ext   = LimWidth'(hold_polls);
      window_ext = LimWidth'(window_ticks);
      if (hold_ext == '0) begin
         hold_ext = LimWidth'(1);
      end
      if (hold_ext > CountMax) begin
         hold_ext = CountMax;
      end
      if (window_ext == '0) begin
         window_ext = LimWidth'(1);
      end
      if (window_ext > CountMax) begin
         window_ext = CountMax;
      end
      hold_lim   = hold_ext[COUNT_WIDTH-1:0];
      window_lim = window_ext[COUNT_WIDTH-1:0];
   end

   // saturating tick count
   assign count_inc = (count_ff == '1) ? count_ff : count_ff + COUNT_WIDTH'(1);
   assign edge_seen = edge_ff | press_edge;

   // next phase and result for one tick
   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      edge_in        = edge_ff;
      result.valid   = 1'b0;
      result.gesture = GESTURE_LONG;
      unique case (phase_ff)
         PHASE_HOLD: begin
            if (pin_level) begin
               // released early: open the double-click window
               edge_in  = 1'b0;
               count_in = '0;
               phase_in = PHASE_WINDOW;
            end else if (count_inc >= hold_lim) begin
               phase_in       = PHASE_IDLE;
               count_in       = '0;
               edge_in        = 1'b0;
               result.valid   = 1'b1;
               result.gesture = GESTURE_LONG;
            end else begin
               count_in = count_inc;
            end
         end
         PHASE_WINDOW: begin
            if (count_inc >= window_lim) begin
               phase_in       = PHASE_IDLE;
               count_in       = '0;
               edge_in        = 1'b0;
               result.valid   = 1'b1;
               result.gesture = edge_seen ? GESTURE_DOUBLE : GESTURE_SINGLE;
            end else begin
               count_in = count_inc;
               edge_in  = edge_seen;
            end
         end
         default: begin
            // idle, and the unused code behaves as idle
            if (edge_seen) begin
               edge_in  = 1'b0;
               count_in = '0;
               phase_in = PHASE_HOLD;
            end else begin
               edge_in  = 1'b0;
               phase_in = PHASE_IDLE;
            end
         end
      endcase
      if (!tick_accept) begin
         result.valid = 1'b0;
      end
   end

   // state registers, updated once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         count_ff <= '0;
         edge_ff  <= 1'b0;
      end else if (tick_accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         edge_ff  <= edge_in;
      end
   end

   assign phase_idle = (phase_ff == PHASE_IDLE);

endmodule

@@ rtl/bgc_out_reg.sv @@
// output register for classifier results with stream handshake
`timescale 1ns / 1ps

module bgc_out_reg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  bgc_pkg::bgc_result_type              result,
   input  logic                                 out_ready,
   output logic                                 out_valid,
   output logic [bgc_pkg::GESTURE_WIDTH-1:0]    out_gesture,
   output logic                                 can_load
);
   import bgc_pkg::*;

   logic                     valid_ff;
   logic [GESTURE_WIDTH-1:0] gesture_ff;

   // room for a new result when empty or being drained this cycle
   assign can_load = !valid_ff || out_ready;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= result.valid;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         gesture_ff <= result.gesture;
      end
   end

   assign out_valid   = valid_ff;
   assign out_gesture = gesture_ff;

endmodule

@@ rtl/button_gesture_classifier.sv @@
// top level of the button gesture classifier
// Usage:
//   Each request on req_ is one poll tick: tdata[0] the active-low pin level,
//   tdata[1] set when a falling edge was seen since the previous tick.
//   A tick that completes a gesture gives one response on rsp_ with the code
//   in tdata[1:0]: long press, double click or single click; other ticks give
//   nothing. The response is registered and appears in the cycle after the tick.
//   Throughput is one request per cycle unless stalled: the phase update
//   and counter compare sit between the state and output registers.
//   While rsp_tready is low and a response is held, req_tready drops, so no
//   result is ever lost; an empty output register takes requests regardless.
//   The csr_ port writes hold_polls (index 0) and window_ticks (index 1);
//   other indexes are ignored. csr_ready is always high. Write only when idle.
//   Synchronous reset returns the phase to idle, clears the counter and edge
//   latch, empties the output register and loads hold_polls = 60 and
//   window_ticks = 6.
`timescale 1ns / 1ps

module button_gesture_classifier #(
   parameter int unsigned COUNT_WIDTH = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // tick requests
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bgc_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,  // pin_level, press_edge, zero fill
   // gesture responses
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bgc_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,  // gesture, zero fill
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bgc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bgc_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import bgc_pkg::*;

   logic [CSR_DATA_WIDTH-1:0] hold_polls_ff;
   logic [CSR_DATA_WIDTH-1:0] window_ticks_ff;
   logic                      tick_accept;
   logic                      can_load;
   logic                      phase_idle;
   logic [GESTURE_WIDTH-1:0]  rsp_gesture;
   bgc_result_type            core_result;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_polls_ff   <= HOLD_POLLS_RESET;
         window_ticks_ff <= WINDOW_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HOLD_POLLS:   hold_polls_ff   <= csr_data;
            CSR_WINDOW_TICKS: window_ticks_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // request handshake
   assign req_tready  = can_load;
   assign tick_accept = req_tvalid && req_tready;

   bgc_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .tick_accept  (tick_accept),
      .pin_level    (req_tdata[0]),
      .press_edge   (req_tdata[1]),
      .hold_polls   (hold_polls_ff),
      .window_ticks (window_ticks_ff),
      .result       (core_result),
      .phase_idle   (phase_idle)
   );

   bgc_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (tick_accept),
      .result      (core_result),
      .out_ready   (rsp_tready),
      .out_valid   (rsp_tvalid),
      .out_gesture (rsp_gesture),
      .can_load    (can_load)
   );

   assign rsp_tdata = {{(RSP_DATA_WIDTH-GESTURE_WIDTH){1'b0}}, rsp_gesture};

   // checks

   // a held response blocks new ticks
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("tick accepted while response stalled");

   // every reported gesture returns the phase to idle
   assert property (@(posedge clock) disable iff (reset)
      core_result.valid |=> phase_idle)
      else $error("phase not idle after gesture");

   // only defined gesture codes leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3))
      else $error("undefined gesture code");

   // a result is produced only on an accepted tick
   assert property (@(posedge clock) disable iff (reset)
      core_result.valid |-> tick_accept)
      else $error("result without accepted tick");

   // output register is empty right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

@@ tb/sv/tb_button_gesture_classifier.sv @@
// self-checking testbench for the button gesture classifier
`timescale 1ns / 1ps

module tb_button_gesture_classifier;
   import bgc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_OFF_CYCLES = 250;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned REPORT_LIMIT = 10;

   // indexes past the register list, writes there must be dropped
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 2'd3;

   typedef enum logic [1:0] {PH_IDLE, PH_HOLD, PH_WINDOW} phase_type;

   // expected gestures, worked out from the accepted ticks
   class gesture_scoreboard;
      logic [CSR_DATA_WIDTH-1:0] hold_polls;
      logic [CSR_DATA_WIDTH-1:0] window_ticks;
      phase_type                 phase;
      logic [7:0]                tick_count;
      logic                      edge_pending;
      logic [GESTURE_WIDTH-1:0]  gestures_due[$];
      int                        mismatches;
      int                        ticks_seen;
      int                        long_count;
      int                        double_count;
      int                        single_count;

      function new();
         hold_polls   = HOLD_POLLS_RESET;
         window_ticks = WINDOW_TICKS_RESET;
         phase        = PH_IDLE;
         tick_count   = '0;
         edge_pending = 1'b0;
         mismatches   = 0;
         ticks_seen   = 0;
         long_count   = 0;
         double_count = 0;
         single_count = 0;
      endfunction

      // a zero limit counts as one
      function logic [7:0] limit_of(logic [CSR_DATA_WIDTH-1:0] value);
         return (value == '0) ? 8'd1 : value;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] index,
                              logic [CSR_DATA_WIDTH-1:0] value);
         if (index == CSR_HOLD_POLLS)
            hold_polls = value;
         else if (index == CSR_WINDOW_TICKS)
            window_ticks = value;
      endfunction

      function void finish_gesture(logic [GESTURE_WIDTH-1:0] gesture);
         gestures_due.push_back(gesture);
         phase        = PH_IDLE;
         tick_count   = '0;
         edge_pending = 1'b0;
      endfunction

      // one accepted tick request
      function void note_tick(logic pin, logic press);
         ticks_seen++;
         case (phase)
            PH_HOLD: begin
               if (pin) begin
                  // released early, latch cleared and window opens
                  edge_pending = 1'b0;
                  tick_count   = '0;
                  phase        = PH_WINDOW;
               end else begin
                  if (tick_count != 8'hff)
                     tick_count++;
                  if (tick_count >= limit_of(hold_polls))
                     finish_gesture(GESTURE_LONG);
               end
            end
            PH_WINDOW: begin
               edge_pending |= press;
               if (tick_count != 8'hff)
                  tick_count++;
               if (tick_count >= limit_of(window_ticks))
                  finish_gesture(edge_pending ? GESTURE_DOUBLE : GESTURE_SINGLE);
            end
            default: begin
               // edge of the entering tick acts at once, pin not sampled
               phase = PH_IDLE;
               edge_pending |= press;
               if (edge_pending) begin
                  edge_pending = 1'b0;
                  tick_count   = '0;
                  phase        = PH_HOLD;
               end
            end
         endcase
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%t: %s", $realtime, msg);
      endfunction

      // one accepted gesture response
      function void check_gesture(logic [RSP_DATA_WIDTH-1:0] data);
         logic [GESTURE_WIDTH-1:0] want;
         if (gestures_due.size() == 0) begin
            flag($sformatf("unexpected gesture response: expected none, got data %02h",
                           data));
            return;
         end
         want = gestures_due.pop_front();
         case (want)
            GESTURE_LONG:   long_count++;
            GESTURE_DOUBLE: double_count++;
            default:        single_count++;
         endcase
         if (data[GESTURE_WIDTH-1:0] !== want)
            flag($sformatf("gesture mismatch: expected %0d, got %0d",
                           want, data[GESTURE_WIDTH-1:0]));
         if (data[RSP_DATA_WIDTH-1:GESTURE_WIDTH] !== '0)
            flag($sformatf("fill bits: expected zero, got response data %02h", data));
      endfunction

      function int pending();
         return gestures_due.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_WIDTH-1:0]  req_tdata = '0;   // pin_level, press_edge, zero fill
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]  rsp_tdata;        // gesture, zero fill
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   gesture_scoreboard sb = new();
   bit                idle_on = 1'b1;
   bit                hold_off_req = 1'b0;
   int                settings_used = 0;
   int unsigned       cycle_count = 0;

   button_gesture_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_button_gesture_classifier: done, errors");
      $finish;
   end

   // response side: random stalls plus an occasional long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end
         rsp_tready = !(idle_on && $urandom_range(0, 99) < 12);
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            sb.check_gesture(rsp_tdata);
      end
   end

   // offer one tick request, returns at the accepting edge
   task automatic send_tick(input logic pin, input logic press);
      @(negedge clock);
      while (idle_on && $urandom_range(0, 99) < 12) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {{(REQ_DATA_WIDTH-2){1'b0}}, press, pin};
      do @(posedge clock); while (!req_tready);
      sb.note_tick(pin, press);
   endtask

   // stop offering and wait for every outstanding gesture
   task automatic wait_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, value);
   endtask

   // bring the block to idle, then load both limits and poke the spare indexes
   task automatic set_limits(input logic [CSR_DATA_WIDTH-1:0] hold,
                             input logic [CSR_DATA_WIDTH-1:0] window);
      while (sb.phase != PH_IDLE) send_tick(1'b1, 1'b0);
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_HOLD_POLLS, hold);
      write_csr(CSR_SPARE_LO, CSR_DATA_WIDTH'($urandom_range(0, 255)));
      write_csr(CSR_WINDOW_TICKS, window);
      write_csr(CSR_SPARE_HI, CSR_DATA_WIDTH'($urandom_range(0, 255)));
      @(negedge clock);
      csr_valid = 1'b0;
      settings_used++;
   endtask

   // one press sequence with random content, or a short burst of noise
   task automatic press_sequence();
      int unsigned kind;
      int unsigned low_ticks;
      int unsigned window_len;
      bit          second;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         repeat ($urandom_range(1, 4))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         return;
      end
      low_ticks  = $urandom_range(0, sb.limit_of(sb.hold_polls) + 1);
      window_len = $urandom_range(0, sb.limit_of(sb.window_ticks) + 1);
      second     = 1'($urandom_range(0, 1));
      send_tick(1'b0, 1'b1);
      repeat (low_ticks) send_tick(1'b0, $urandom_range(0, 7) == 0);
      send_tick(1'b1, 1'($urandom_range(0, 1)));
      repeat (window_len)
         send_tick($urandom_range(0, 3) != 0, second && $urandom_range(0, 3) == 0);
   endtask

   task automatic random_ticks(input int count);
      int target;
      target = sb.ticks_seen + count;
      while (sb.ticks_seen < target) press_sequence();
   endtask

   // stimulus
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: long press, single click, double click, edges ignored while held
      set_limits(8'd2, 8'd3);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);

      // shortest limits, no idling on either side
      set_limits(8'd1, 8'd1);
      idle_on = 1'b0;
      random_ticks(150);
      idle_on = 1'b1;

      // zero limits behave as one
      set_limits(8'd0, 8'd0);
      random_ticks(150);

      // small limits with a long receiver hold-off
      set_limits(CSR_DATA_WIDTH'($urandom_range(1, 12)),
                 CSR_DATA_WIDTH'($urandom_range(1, 12)));
      random_ticks(40);
      hold_off_req = 1'b1;
      random_ticks(110);

      // largest limits
      set_limits(8'd255, 8'd255);
      random_ticks(150);

      // moderate limits with a full pause in the middle
      set_limits(CSR_DATA_WIDTH'($urandom_range(1, 30)),
                 CSR_DATA_WIDTH'($urandom_range(1, 30)));
      random_ticks(75);
      wait_results();
      random_ticks(75);

      // back to the reset values
      set_limits(HOLD_POLLS_RESET, WINDOW_TICKS_RESET);
      random_ticks(200);

      wait_results();
      repeat (SETTLE_CYCLES * 4) @(posedge clock);

      $display("ran %0d ticks over %0d limit settings in %0d cycles",
               sb.ticks_seen, settings_used, cycle_count);
      $display("gestures checked: %0d long, %0d double, %0d single; %0d mismatches",
               sb.long_count, sb.double_count, sb.single_count, sb.mismatches);
      if (sb.mismatches == 0)
         $display("tb_button_gesture_classifier: done, clean");
      else
         $display("tb_button_gesture_classifier: done, errors");
      $finish;
   end

endmodule
